### src/mrv_pkg.sv
// Shared constants, types and codes for the microcoded reverb processor.
`timescale 1ns / 1ps

package mrv_pkg;

    // Sizes of the delay line, of one program and of the microcode store.
    // DELAY_WORDS must be a power of two, since the address wraps by truncation.
    localparam int DELAY_WORDS      = 16384;
    localparam int STEPS_PER_SAMPLE = 128;
    localparam int PROGRAM_SLOTS    = 64;
    localparam int STORE_WORDS      = PROGRAM_SLOTS * STEPS_PER_SAMPLE;

    localparam int DELAY_AW = $clog2(DELAY_WORDS);
    localparam int STORE_AW = $clog2(STORE_WORDS);
    localparam int STEP_W   = $clog2(STEPS_PER_SAMPLE);
    localparam int INC_W    = 14;
    localparam int ASUM_W   = (DELAY_AW > INC_W) ? DELAY_AW : INC_W;

    // The highest program that produces sound.
    localparam logic [7:0] LAST_PROGRAM = 8'd62;
    localparam logic [7:0] PROG_RESET   = 8'd255;

    // Steps whose bus value is taken as an output sample.
    localparam logic [STEP_W-1:0] TAP_RIGHT = STEP_W'(8'h60);
    localparam logic [STEP_W-1:0] TAP_LEFT  = STEP_W'(8'h70);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_PER_SAMPLE - 1);

    // Output saturation limits (13-bit signed range).
    localparam logic signed [15:0] SAT_HI = 16'sd4095;
    localparam logic signed [15:0] SAT_LO = -16'sd4096;

    // Request kinds.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // Microcode opcode in bits 15:14 of a word.
    typedef enum logic [1:0] {
        OP_MEM_ACC  = 2'd0,
        OP_MEM      = 2'd1,
        OP_ACC      = 2'd2,
        OP_ACC_INV  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_RUN   = 2'd2,
        ST_FLUSH = 2'd3
    } t_state;

    // Control of one step, from the sequencer to the step unit.
    typedef struct packed {
        logic    first;
        logic    tap;
        t_opcode op;
    } t_step_ctl;

    // Results of one step, from the step unit back to the sequencer.
    typedef struct packed {
        logic               mem_we;
        logic signed [15:0] bus;
        logic               acc_we;
        logic signed [15:0] acc_nxt;
        logic signed [15:0] tap_out;
    } t_step_res;

endpackage

### src/mrv_code_store.sv
// Microcode store: one write port for loads, one registered read port.
`timescale 1ns / 1ps

module mrv_code_store (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [mrv_pkg::STORE_AW-1:0] i_waddr,
    input  logic [15:0]                  i_wdata,
    input  logic [mrv_pkg::STORE_AW-1:0] i_raddr,
    output logic [15:0]                  o_rdata
);
    import mrv_pkg::*;

    logic [15:0] r_mem [STORE_WORDS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mrv_delay_ram.sv
// Delay line memory: one write port, one registered read port (old data on collision).
`timescale 1ns / 1ps

module mrv_delay_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [mrv_pkg::DELAY_AW-1:0] i_waddr,
    input  logic [15:0]                  i_wdata,
    input  logic [mrv_pkg::DELAY_AW-1:0] i_raddr,
    output logic [15:0]                  o_rdata
);
    import mrv_pkg::*;

    logic [15:0] r_mem [DELAY_WORDS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mrv_step_unit.sv
// Shared step datapath: bus source select, accumulate and output saturation.
`timescale 1ns / 1ps

module mrv_step_unit (
    input  mrv_pkg::t_step_ctl  i_ctl,
    input  logic signed [15:0]  i_left,
    input  logic signed [15:0]  i_right,
    input  logic signed [15:0]  i_acc,
    input  logic signed [15:0]  i_mem,
    output mrv_pkg::t_step_res  o_res
);
    import mrv_pkg::*;

    logic signed [15:0] mix_sum;
    logic signed [15:0] bus;
    logic signed [15:0] acc_keep;
    logic signed [15:0] sat;

    always_comb begin
        // Both inputs are floored by 16 before the mix; the low bit is then cleared.
        mix_sum = (i_left >>> 4) + (i_right >>> 4);

        unique case (i_ctl.op)
            OP_MEM_ACC, OP_MEM: bus = i_mem;
            OP_ACC:             bus = i_acc;
            OP_ACC_INV:         bus = ~i_acc;
            default:            bus = i_mem;
        endcase
        if (i_ctl.first) begin
            bus = {mix_sum[15:1], 1'b0};
        end

        // Opcodes with bit 0 set restart the sum instead of adding to it.
        acc_keep = (i_ctl.op == OP_MEM || i_ctl.op == OP_ACC_INV) ? 16'sd0 : i_acc;

        if (bus > SAT_HI) begin
            sat = SAT_HI;
        end else if (bus < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = bus;
        end

        o_res.bus     = bus;
        o_res.mem_we  = i_ctl.first || i_ctl.op == OP_ACC || i_ctl.op == OP_ACC_INV;
        o_res.acc_we  = !i_ctl.tap;
        o_res.acc_nxt = (bus >>> 1) + acc_keep + $signed({15'd0, bus[15]});
        o_res.tap_out = {sat[12:0], 3'b000};
    end

endmodule

### src/microcoded_reverb_dsp_top.sv
// Top level of the microcoded reverb processor: sequencer, state registers and output beat.
`timescale 1ns / 1ps
// Sequence: a sample beat runs 128 microcode steps, one per cycle, then its result beat is
// offered once the output register is free; load beats and muted samples answer from idle.
// A new sample beat is taken only back in idle, set by the single shared step unit and the
// one read and one write port of the delay memory. Reset is synchronous, active low; after
// it the block clears all DELAY_WORDS (16384) delay words and stalls meanwhile.

module microcoded_reverb_dsp_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration: program select register.
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic signed [15:0] i_left_in,
    input  logic signed [15:0] i_right_in,
    input  logic [12:0]        i_code_address,
    input  logic [15:0]        i_code_word,
    // Output channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_left_out,
    output logic signed [15:0] o_right_out
);
    import mrv_pkg::*;

    // Control state.
    t_state                r_state, n_state;
    logic [7:0]            r_prog;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [DELAY_AW-1:0]   r_clr, n_clr;
    logic signed [15:0]    r_acc, n_acc;
    logic [DELAY_AW-1:0]   r_addr, n_addr;
    logic                  r_fwd, n_fwd;
    logic                  r_out_valid, n_out_valid;

    // Payload registers.
    logic signed [15:0]    r_lin, r_rin;
    logic signed [15:0]    r_fwd_data;
    logic signed [15:0]    r_res_l, n_res_l, r_res_r, n_res_r;
    logic signed [15:0]    r_out_l, n_out_l, r_out_r, n_out_r;

    // Handshake and datapath wires.
    logic                  slot_free;
    logic                  in_fire;
    logic                  muted;
    logic                  load_ok;
    logic [15:0]           load_addr_ext;
    logic [STEP_W-1:0]     code_step;
    logic [7+STEP_W:0]     code_idx;
    logic [15:0]           code_q;
    logic [15:0]           dly_q;
    logic                  dly_we;
    logic [DELAY_AW-1:0]   dly_waddr;
    logic [15:0]           dly_wdata;
    logic [DELAY_AW-1:0]   dly_raddr;
    logic [ASUM_W-1:0]     addr_sum;
    logic [DELAY_AW-1:0]   addr_adv;
    logic signed [15:0]    mem_val;
    t_step_ctl             step_ctl;
    t_step_res             step_res;

    // The output register is free when empty or when its beat leaves at this edge.
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(r_state == ST_IDLE && slot_free);
    assign in_fire    = i_in_valid && !o_in_stall;

    // Programs beyond the last usable one, or beyond the store, mute the sample.
    assign muted = (r_prog > LAST_PROGRAM) || ({1'b0, r_prog} >= 9'(PROGRAM_SLOTS));

    // Load beats write the microcode store directly; addresses past its end are dropped.
    assign load_addr_ext = {3'd0, i_code_address};
    assign load_ok = in_fire && i_req_type == REQ_LOAD && load_addr_ext < 16'(STORE_WORDS);

    // The code word is fetched one step ahead: the word of step 0 at acceptance, and
    // the word of the following step in every run cycle.
    assign code_step = (r_state == ST_RUN) ? r_step + 1'b1 : '0;
    assign code_idx  = {r_prog, code_step};

    mrv_code_store u_code_store (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (load_addr_ext[STORE_AW-1:0]),
        .i_wdata (i_code_word),
        .i_raddr (code_idx[STORE_AW-1:0]),
        .o_rdata (code_q)
    );

    // Address of the next step: the delay address wraps by truncation.
    assign addr_sum = ASUM_W'(r_addr) + ASUM_W'(code_q[INC_W-1:0]);
    assign addr_adv = addr_sum[DELAY_AW-1:0];

    // The delay read for the next step is issued during the current step. When the increment is
    // zero it hits the word written in the same cycle, so that value is forwarded.
    assign dly_raddr = (r_state == ST_RUN) ? addr_adv : r_addr;
    assign mem_val   = r_fwd ? r_fwd_data : $signed(dly_q);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            dly_we    = 1'b1;
            dly_waddr = r_clr;
            dly_wdata = '0;
        end else begin
            dly_we    = (r_state == ST_RUN) && step_res.mem_we;
            dly_waddr = r_addr;
            dly_wdata = step_res.bus;
        end
    end

    mrv_delay_ram u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (dly_waddr),
        .i_wdata (dly_wdata),
        .i_raddr (dly_raddr),
        .o_rdata (dly_q)
    );

    assign step_ctl.first = (r_step == '0);
    assign step_ctl.tap   = (r_step == TAP_RIGHT) || (r_step == TAP_LEFT);
    assign step_ctl.op    = t_opcode'(code_q[15:14]);

    mrv_step_unit u_step_unit (
        .i_ctl   (step_ctl),
        .i_left  (r_lin),
        .i_right (r_rin),
        .i_acc   (r_acc),
        .i_mem   (mem_val),
        .o_res   (step_res)
    );

    // Sequencer: clearing pass, idle, one step per cycle, then hand-off to the output.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_clr       = r_clr;
        n_acc       = r_acc;
        n_addr      = r_addr;
        n_fwd       = 1'b0;
        n_res_l     = r_res_l;
        n_res_r     = r_res_r;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == DELAY_AW'(DELAY_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_req_type == REQ_SAMPLE && !muted) begin
                        n_state = ST_RUN;
                        n_step  = '0;
                    end else begin
                        n_out_l     = '0;
                        n_out_r     = '0;
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                n_addr = addr_adv;
                n_fwd  = step_res.mem_we && (addr_adv == r_addr);
                if (step_res.acc_we) begin
                    n_acc = step_res.acc_nxt;
                end
                if (r_step == TAP_RIGHT) begin
                    n_res_r = step_res.tap_out;
                end
                if (r_step == TAP_LEFT) begin
                    n_res_l = step_res.tap_out;
                end
                if (r_step == STEP_LAST) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_out_l     = r_res_l;
                    n_out_r     = r_res_r;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_prog      <= PROG_RESET;
            r_step      <= '0;
            r_clr       <= '0;
            r_acc       <= '0;
            r_addr      <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_clr       <= n_clr;
            r_acc       <= n_acc;
            r_addr      <= n_addr;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_prog <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_lin <= i_left_in;
            r_rin <= i_right_in;
        end
        r_fwd_data <= step_res.bus;
        r_res_l    <= n_res_l;
        r_res_r    <= n_res_r;
        r_out_l    <= n_out_l;
        r_out_r    <= n_out_r;
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

    // A run, once started, continues without a break until its last step.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step != STEP_LAST) |=> (r_state == ST_RUN))
        else $error("step sequence broke off before the last step");

    // The delay memory is written only by the clearing pass or by a running step.
    a_delay_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_FLUSH) |-> !dly_we)
        else $error("delay memory written outside a run");

    // A new result beat appears only after an immediate answer or a finished run.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_IDLE || $past(r_state) == ST_FLUSH))
        else $error("result beat raised from an unexpected state");

    // No input beat is taken while a result beat would be left without a place.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (!r_out_valid || !i_out_stall))
        else $error("input beat accepted while the output register is blocked");

endmodule
